/* hdl/min_max_contiguous_partition_assert.svh */
// ----------------------------------------------------------------------------
// min_max_contiguous_partition_assert.svh
// assertion macros used by the partition block checker
// ----------------------------------------------------------------------------
`ifndef MIN_MAX_CONTIGUOUS_PARTITION_ASSERT_SVH
`define MIN_MAX_CONTIGUOUS_PARTITION_ASSERT_SVH

// property checked at every rising edge, quiet while reset is high
`define MMCP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every rising edge, reset included
`define MMCP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/mmcp_pkg.sv */
// ----------------------------------------------------------------------------
// mmcp_pkg
// widths and register codes of the contiguous partition block
// ----------------------------------------------------------------------------
package mmcp_pkg;

   localparam int WEIGHT_IN_BITS = 16;
   localparam int LOAD_BITS      = 24;
   localparam int GROUP_BITS     = 9;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 3;

   localparam logic [LOAD_BITS-1:0]  LOAD_MAX          = '1;
   localparam logic [GROUP_BITS-1:0] GROUP_COUNT_RESET = GROUP_BITS'(1);

   // register index, taken from address bit 2
   localparam logic CSR_IDX_GROUP_COUNT = 1'b0;

endpackage

/* hdl/min_max_contiguous_partition.sv */
// ----------------------------------------------------------------------------
// min_max_contiguous_partition
// smallest maximum group load for a contiguous split, by binary search
// ----------------------------------------------------------------------------
// Weights stream in one transfer per cycle and are written to an internal
// store of MAX_ITEMS entries while their count, total and maximum are kept;
// items past a full store are dropped but tlast still closes the set. On the
// transfer with tlast the block stops taking input and binary-searches the
// load limit between the maximum and the total. Each probe walks the store
// through its single registered read port and one shared add/compare unit;
// a search takes at most floor(log2(total - max + 1)) + 1 probes, with setup
// before them and the closing range check and hand-off after them (no range
// check when the search ends on a zero load, only setup and hand-off when no
// probe is needed). Hand-off waits as long as an earlier result is
// still held in the output register. The result (load and a possible flag in
// tuser) sits in that register, so the next set may start loading while it
// waits to be taken. Asking for zero groups or more groups than items gives
// possible = 0 and load 0; a load that does not fit 24 bits saturates.
// ----------------------------------------------------------------------------
module min_max_contiguous_partition
   import mmcp_pkg::*;
#(
   parameter int MAX_ITEMS   = 256,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // input stream
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [15:0]              req_tdata,   // [15:0] weight
   input  logic                     req_tlast,   // last_item
   // result stream
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [23:0]              rsp_tdata,   // [23:0] min_max_load
   output logic                     rsp_tuser,   // possible
   // configuration port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int ADDR_BITS = $clog2(MAX_ITEMS);
   localparam int CNT_BITS  = $clog2(MAX_ITEMS + 1);
   localparam int TOT_BITS  = WEIGHT_BITS + CNT_BITS;
   localparam int USED_BITS = CNT_BITS + 1;
   localparam int CMP_BITS  = (USED_BITS > GROUP_BITS) ? USED_BITS : GROUP_BITS;
   localparam int IN_BITS   = (WEIGHT_BITS > WEIGHT_IN_BITS) ? WEIGHT_BITS : WEIGHT_IN_BITS;
   localparam int SAT_BITS  = (TOT_BITS > LOAD_BITS) ? TOT_BITS : LOAD_BITS;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_CHECK,
      ST_PROBE,
      ST_WALK,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   // set statistics
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [TOT_BITS-1:0]    total_ff, total_in;
   logic [WEIGHT_BITS-1:0] max_ff, max_in;
   logic [GROUP_BITS-1:0]  group_count_ff, group_count_in;

   // search state
   logic [TOT_BITS-1:0]    lo_ff, lo_in;
   logic [TOT_BITS-1:0]    hi_ff, hi_in;
   logic [TOT_BITS-1:0]    mid_ff, mid_in;
   logic [TOT_BITS-1:0]    best_ff, best_in;
   logic                   ok_ff, ok_in;

   // probe walk
   logic [CNT_BITS-1:0]    rd_idx_ff, rd_idx_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic [USED_BITS-1:0]   used_ff, used_in;
   logic [TOT_BITS-1:0]    load_ff, load_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LOAD_BITS-1:0]   rsp_load_ff, rsp_load_in;
   logic                   rsp_possible_ff, rsp_possible_in;

   // weight store
   logic [WEIGHT_BITS-1:0] weight_mem [MAX_ITEMS];
   logic [WEIGHT_BITS-1:0] rd_data_ff;
   logic                   mem_we;

   logic [IN_BITS-1:0]     w_wide;
   logic [WEIGHT_BITS-1:0] w_in;
   logic                   req_xfer;
   logic                   csr_write;
   logic [TOT_BITS:0]      walk_sum;
   logic [SAT_BITS-1:0]    best_ext;
   logic [LOAD_BITS-1:0]   best_sat;
   logic                   fits;

   assign w_wide   = IN_BITS'(req_tdata);
   assign w_in     = w_wide[WEIGHT_BITS-1:0];
   assign req_xfer = req_tvalid && req_tready;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_BITS-1] == CSR_IDX_GROUP_COUNT) ?
                       CSR_DATA_BITS'(group_count_ff) : '0;

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_load_ff;
   assign rsp_tuser  = rsp_possible_ff;

   // shared add/compare unit of the greedy walk
   assign walk_sum = {1'b0, load_ff} + (TOT_BITS + 1)'(rd_data_ff);
   assign fits     = CMP_BITS'(used_ff) <= CMP_BITS'(group_count_ff);

   assign best_ext = SAT_BITS'(best_ff);
   assign best_sat = (best_ext > SAT_BITS'(LOAD_MAX)) ? LOAD_MAX : best_ext[LOAD_BITS-1:0];

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      total_in        = total_ff;
      max_in          = max_ff;
      group_count_in  = group_count_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      best_in         = best_ff;
      ok_in           = ok_ff;
      rd_idx_in       = rd_idx_ff;
      rd_pend_in      = rd_pend_ff;
      used_in         = used_ff;
      load_in         = load_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_load_in     = rsp_load_ff;
      rsp_possible_in = rsp_possible_ff;
      mem_we          = 1'b0;

      if (csr_write && (csr_paddr[CSR_ADDR_BITS-1] == CSR_IDX_GROUP_COUNT)) begin
         group_count_in = csr_pwdata[GROUP_BITS-1:0];
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               // a full store drops the item
               if (count_ff < CNT_BITS'(MAX_ITEMS)) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + 1'b1;
                  total_in = total_ff + TOT_BITS'(w_in);
                  if (w_in > max_ff) begin
                     max_in = w_in;
                  end
               end
               if (req_tlast) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            ok_in   = 1'b0;
            best_in = '0;
            lo_in   = TOT_BITS'(max_ff);
            hi_in   = total_ff;
            // no groups, or more groups than items
            if ((group_count_ff == '0) ||
                (CMP_BITS'(group_count_ff) > CMP_BITS'(count_ff))) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (lo_ff > hi_ff) begin
               state_in = ST_FINISH;
            end else begin
               mid_in     = lo_ff + ((hi_ff - lo_ff) >> 1);
               used_in    = USED_BITS'(1);
               load_in    = '0;
               rd_idx_in  = '0;
               rd_pend_in = 1'b0;
               state_in   = ST_WALK;
            end
         end
         ST_WALK: begin
            // issue the next read
            if (rd_idx_ff < count_ff) begin
               rd_idx_in  = rd_idx_ff + 1'b1;
               rd_pend_in = 1'b1;
            end else begin
               rd_pend_in = 1'b0;
            end
            // take the item read last cycle
            if (rd_pend_ff) begin
               if (walk_sum <= {1'b0, mid_ff}) begin
                  load_in = walk_sum[TOT_BITS-1:0];
               end else begin
                  used_in = used_ff + 1'b1;
                  load_in = TOT_BITS'(rd_data_ff);
               end
            end
            if ((rd_idx_ff == count_ff) && !rd_pend_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (fits) begin
               best_in = mid_ff;
               ok_in   = 1'b1;
               if (mid_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  hi_in    = mid_ff - 1'b1;
                  state_in = ST_PROBE;
               end
            end else begin
               lo_in    = mid_ff + 1'b1;
               state_in = ST_PROBE;
            end
         end
         ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in    = 1'b1;
               rsp_load_in     = ok_ff ? best_sat : '0;
               rsp_possible_in = ok_ff;
               count_in        = '0;
               total_in        = '0;
               max_in          = '0;
               state_in        = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         count_ff       <= '0;
         total_ff       <= '0;
         max_ff         <= '0;
         group_count_ff <= GROUP_COUNT_RESET;
         rsp_valid_ff   <= 1'b0;
         rd_pend_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         total_ff       <= total_in;
         max_ff         <= max_in;
         group_count_ff <= group_count_in;
         rsp_valid_ff   <= rsp_valid_in;
         rd_pend_ff     <= rd_pend_in;
      end
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      mid_ff          <= mid_in;
      best_ff         <= best_in;
      ok_ff           <= ok_in;
      rd_idx_ff       <= rd_idx_in;
      used_ff         <= used_in;
      load_ff         <= load_in;
      rsp_load_ff     <= rsp_load_in;
      rsp_possible_ff <= rsp_possible_in;
   end

   // weight store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         weight_mem[count_ff[ADDR_BITS-1:0]] <= w_in;
      end
      rd_data_ff <= weight_mem[rd_idx_ff[ADDR_BITS-1:0]];
   end

endmodule

/* hdl/mmcp_checker.sv */
// ----------------------------------------------------------------------------
// mmcp_checker
// port-level checks of the contiguous partition block
// ----------------------------------------------------------------------------
`include "min_max_contiguous_partition_assert.svh"

module mmcp_checker
   import mmcp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a held result keeps its payload
   `MMCP_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // an impossible split reports a zero load
   `MMCP_ASSERT(a_impossible_zero, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0, "impossible result with nonzero load")

   // the search runs after the closing transfer, input stays closed
   `MMCP_ASSERT(a_closed_after_last, clock, reset, req_tvalid && req_tready && req_tlast |=> !req_tready, "input open right after the closing transfer")

   // reset empties the output register
   `MMCP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind min_max_contiguous_partition mmcp_checker u_mmcp_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the min-max contiguous partition block
// ----------------------------------------------------------------------------
// Weight sets stream into the block and each set ends in one load result.
// A behavioral copy of the search runs on each set's closing weight and queues
// the expected load and possible flag. Each result transfer is compared
// against the oldest queued entry. A short table of hand-picked sets comes
// first. Random sets follow, split into batches with a new group count per
// batch. There are three idling profiles, one long receiver stall and one
// set of maximum weights that fills the store and runs past it.
// ----------------------------------------------------------------------------
module tb_top
   import mmcp_pkg::*;
();

   localparam int STORE_DEPTH = 256;        // matches the block's default depth
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int LONG_STALL  = 600;        // receiver hold-off, in cycles
   localparam int SETTLE      = 8;          // quiet cycles before a register write

   // directed table flags
   localparam logic WR_CFG = 1'b1;   // write group_count before this row's item
   localparam logic NO_CFG = 1'b0;
   localparam logic TYPED  = 1'b1;   // result typed into the row
   localparam logic MODEL  = 1'b0;   // result taken from the predictor

   typedef struct packed {
      logic [WEIGHT_IN_BITS-1:0] weight;
      logic                      last;
      logic                      typed;
      logic [LOAD_BITS-1:0]      typed_load;
      logic                      typed_ok;
   } weight_item_type;

   typedef struct packed {
      logic [LOAD_BITS-1:0] load;
      logic                 ok;
   } split_result_type;

   typedef struct packed {
      logic                      cfg;
      logic [GROUP_BITS-1:0]     groups;
      logic [WEIGHT_IN_BITS-1:0] weight;
      logic                      last;
      logic                      typed;
      logic [LOAD_BITS-1:0]      exp_load;
      logic                      exp_ok;
   } dir_row_type;

   // hand-picked sets; group_count starts at its reset value of one
   localparam int DIR_ROWS = 23;
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      // single item, reset group count
      '{NO_CFG, 9'd0,   16'd5,     1'b1, TYPED, 24'd5,      1'b1},
      // all-zero set gives a zero load that is still possible
      '{NO_CFG, 9'd0,   16'd0,     1'b0, MODEL, 24'd0,      1'b0},
      '{NO_CFG, 9'd0,   16'd0,     1'b1, TYPED, 24'd0,      1'b1},
      // largest weights in one group
      '{NO_CFG, 9'd0,   16'hFFFF,  1'b0, MODEL, 24'd0,      1'b0},
      '{NO_CFG, 9'd0,   16'hFFFF,  1'b1, TYPED, 24'd131070, 1'b1},
      // two groups split the two largest weights
      '{WR_CFG, 9'd2,   16'hFFFF,  1'b0, MODEL, 24'd0,      1'b0},
      '{NO_CFG, 9'd0,   16'hFFFF,  1'b1, TYPED, 24'd65535,  1'b1},
      // more groups than items
      '{NO_CFG, 9'd0,   16'd7,     1'b1, TYPED, 24'd0,      1'b0},
      // zero groups
      '{WR_CFG, 9'd0,   16'd3,     1'b0, MODEL, 24'd0,      1'b0},
      '{NO_CFG, 9'd0,   16'd4,     1'b1, TYPED, 24'd0,      1'b0},
      // widest group count
      '{WR_CFG, 9'd511, 16'd1,     1'b1, TYPED, 24'd0,      1'b0},
      // textbook five-item split into three groups
      '{WR_CFG, 9'd3,   16'd10,    1'b0, MODEL, 24'd0,      1'b0},
      '{NO_CFG, 9'd0,   16'd20,    1'b0, MODEL, 24'd0,      1'b0},
      '{NO_CFG, 9'd0,   16'd30,    1'b0, MODEL, 24'd0,      1'b0},
      '{NO_CFG, 9'd0,   16'd40,    1'b0, MODEL, 24'd0,      1'b0},
      '{NO_CFG, 9'd0,   16'd50,    1'b1, MODEL, 24'd0,      1'b0},
      // complementary bit patterns in one group
      '{WR_CFG, 9'd1,   16'd1,     1'b0, MODEL, 24'd0,      1'b0},
      '{NO_CFG, 9'd0,   16'h8000,  1'b0, MODEL, 24'd0,      1'b0},
      '{NO_CFG, 9'd0,   16'h7FFF,  1'b1, MODEL, 24'd0,      1'b0},
      // heavy ends, light middle
      '{WR_CFG, 9'd2,   16'd9,     1'b0, MODEL, 24'd0,      1'b0},
      '{NO_CFG, 9'd0,   16'd1,     1'b0, MODEL, 24'd0,      1'b0},
      '{NO_CFG, 9'd0,   16'd1,     1'b0, MODEL, 24'd0,      1'b0},
      '{NO_CFG, 9'd0,   16'd9,     1'b1, MODEL, 24'd0,      1'b0}
   };

   // block ports; every input starts at a known value
   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [15:0]               req_tdata   = '0;    // [15:0] weight
   logic                      req_tlast   = 1'b0;  // last_item
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic [23:0]               rsp_tdata;           // [23:0] min_max_load
   logic                      rsp_tuser;           // possible
   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_prdata;
   logic                      csr_pready;

   // bench state
   weight_item_type           weight_queue[$];     // items waiting to be offered
   split_result_type          expected_loads[$];   // predicted results in order
   logic [WEIGHT_IN_BITS-1:0] set_weights [STORE_DEPTH];
   int                        set_count   = 0;
   longint                    set_total   = 0;
   longint                    set_max     = 0;
   logic [GROUP_BITS-1:0]     cur_groups  = GROUP_COUNT_RESET;
   int                        send_idle   = 0;     // sender idle chance, percent
   int                        rsp_idle    = 0;     // receiver idle chance, percent
   logic                      long_stall_start = 1'b0;
   int                        stall_left  = 0;
   int                        mismatch_count = 0;
   int unsigned               cycle_count = 0;

   min_max_contiguous_partition DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // greedy walk: do the held weights fit into `groups` runs of sum <= limit
   function automatic bit loads_fit(input longint limit, input longint groups);
      longint used;
      longint run;
      used = 1;
      run  = 0;
      for (int i = 0; i < set_count; i++) begin
         if (set_weights[i] > limit) return 1'b0;
         if (run + set_weights[i] <= limit) begin
            run += set_weights[i];
         end else begin
            used++;
            run = set_weights[i];
         end
      end
      return used <= groups;
   endfunction

   // binary search for the smallest limit between the heaviest item and the total
   function automatic split_result_type predict_min_max_load(
      input logic [GROUP_BITS-1:0] groups);
      split_result_type r;
      longint lo;
      longint hi;
      longint mid;
      longint best;
      bit     found;
      best  = 0;
      found = 1'b0;
      if (groups != 0 && groups <= set_count) begin
         lo = set_max;
         hi = set_total;
         while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (loads_fit(mid, groups)) begin
               best  = mid;
               found = 1'b1;
               if (mid == 0) break;
               hi = mid - 1;
            end else begin
               lo = mid + 1;
            end
         end
      end
      if (best > LOAD_MAX) best = LOAD_MAX;
      r.load = found ? LOAD_BITS'(best) : '0;
      r.ok   = found;
      return r;
   endfunction

   // one accepted weight: store it, and on the set's end queue the answer
   task automatic take_weight(input weight_item_type it);
      split_result_type r;
      // a full store drops the weight, but its last flag still closes the set
      if (set_count < STORE_DEPTH) begin
         set_weights[set_count] = it.weight;
         set_count++;
         set_total += it.weight;
         if (it.weight > set_max) set_max = it.weight;
      end
      if (it.last) begin
         r = predict_min_max_load(cur_groups);
         if (it.typed) begin
            r.load = it.typed_load;
            r.ok   = it.typed_ok;
         end
         expected_loads.push_back(r);
         set_count = 0;
         set_total = 0;
         set_max   = 0;
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // input side: offer the queue head, hold it until the transfer
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_weights
      logic took;
      took = req_tvalid && req_tready;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (took) begin
            take_weight(weight_queue[0]);
            void'(weight_queue.pop_front());
         end
         // a new item goes out only when the bus is free or just transferred
         if (!req_tvalid || took) begin
            if (weight_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
               req_tvalid <= 1'b1;
               req_tdata  <= weight_queue[0].weight;
               req_tlast  <= weight_queue[0].last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // result side: random ready, with one long hold-off on request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_stall_start) begin
         long_stall_start = 1'b0;
         stall_left       = LONG_STALL;
         rsp_tready      <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle);
      end
   end

   // compare each result transfer against the oldest prediction
   always @(posedge clock) begin : check_loads
      split_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_loads.size() == 0) begin
            report_mismatch("unexpected result, load", rsp_tdata, 0);
         end else begin
            want = expected_loads.pop_front();
            if (rsp_tdata !== want.load) report_mismatch("min_max_load", rsp_tdata, want.load);
            if (rsp_tuser !== want.ok)   report_mismatch("possible", rsp_tuser, want.ok);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   function automatic void queue_weight(input logic [WEIGHT_IN_BITS-1:0] w, input logic last,
                                        input logic typed, input logic [LOAD_BITS-1:0] load,
                                        input logic ok);
      weight_item_type it;
      it.weight     = w;
      it.last       = last;
      it.typed      = typed;
      it.typed_load = load;
      it.typed_ok   = ok;
      weight_queue.push_back(it);
   endfunction

   // skewed toward small weights to keep searches short, with both extremes
   function automatic logic [WEIGHT_IN_BITS-1:0] random_weight();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return WEIGHT_IN_BITS'($urandom_range(15));
         5, 6:    return WEIGHT_IN_BITS'($urandom_range(1000));
         default: return WEIGHT_IN_BITS'($urandom);
      endcase
   endfunction

   // sender stops until every result is back and the block has gone quiet
   task automatic wait_idle();
      while (weight_queue.size() > 0 || req_tvalid || expected_loads.size() > 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // setup cycle, then access cycle; the write lands with pready high
   task automatic write_group_count(input logic [GROUP_BITS-1:0] groups);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'({CSR_IDX_GROUP_COUNT, 2'b00});
      csr_pwdata  <= CSR_DATA_BITS'(groups);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cur_groups   = groups;
   endtask

   // batches of random sets, each batch under one freshly written group count
   task automatic run_batches(input int item_goal);
      int sent;
      int sets;
      int len;
      logic [GROUP_BITS-1:0] groups;
      sent = 0;
      while (sent < item_goal) begin
         wait_idle();
         case ($urandom_range(11))
            0:       groups = '0;                                  // never satisfiable
            1:       groups = GROUP_BITS'($urandom_range(257, 511)); // beyond any store
            2:       groups = GROUP_BITS'($urandom_range(9, 256));
            3:       groups = GROUP_BITS'(1);
            default: groups = GROUP_BITS'($urandom_range(2, 8));
         endcase
         write_group_count(groups);
         sets = $urandom_range(4, 10);
         for (int s = 0; s < sets; s++) begin
            case ($urandom_range(19))
               0:          len = 1;
               16, 17, 18: len = $urandom_range(11, 40);
               19:         len = $urandom_range(41, 100);
               default:    len = $urandom_range(2, 10);
            endcase
            for (int k = 0; k < len; k++)
               queue_weight(random_weight(), k == len - 1, MODEL, '0, 1'b0);
            sent += len;
         end
      end
      wait_idle();
   endtask

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table, sender idles lightly, receiver heavily
      send_idle = 23;
      rsp_idle  = 54;
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (DIR_TABLE[i].cfg == WR_CFG) begin
            wait_idle();
            write_group_count(DIR_TABLE[i].groups);
         end
         queue_weight(DIR_TABLE[i].weight, DIR_TABLE[i].last, DIR_TABLE[i].typed,
                      DIR_TABLE[i].exp_load, DIR_TABLE[i].exp_ok);
      end
      wait_idle();

      // long receiver hold-off while sets keep coming: output and input back up
      long_stall_start = 1'b1;
      run_batches(80);

      // full store of maximum weights, one item per group; the trailing
      // weights and the closing one are dropped
      write_group_count(GROUP_BITS'(STORE_DEPTH));
      for (int k = 0; k < STORE_DEPTH + 4; k++)
         queue_weight('1, k == STORE_DEPTH + 3, MODEL, '0, 1'b0);
      wait_idle();

      // idling the other way round
      send_idle = 54;
      rsp_idle  = 23;
      run_batches(80);

      // no idling on either side
      send_idle = 0;
      rsp_idle  = 0;
      run_batches(80);

      // quiet tail to catch stray results
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && expected_loads.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
